@@ rtl/column_bitmap_blitter_macros.svh @@
// ----------------------------------------------------------------------------
// column_bitmap_blitter assertion macros
// shared concurrent assertion forms for the blitter checkers
// ----------------------------------------------------------------------------
`ifndef COLUMN_BITMAP_BLITTER_MACROS_SVH
`define COLUMN_BITMAP_BLITTER_MACROS_SVH

// both forms sample on the checker's i_clk and are off while i_rst_n is low

// same-cycle implication, checked outside reset
`define CBB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("blitter assertion failed");

// next-cycle implication, checked outside reset
`define CBB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("blitter assertion failed");

`endif

@@ rtl/cbb_pkg.sv @@
// ----------------------------------------------------------------------------
// cbb_pkg
// shared constants, codes and types of the column bitmap blitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbb_pkg;

    localparam int DISPLAY_COLUMNS = 128;
    localparam int DISPLAY_PAGES   = 8;
    localparam int PATTERN_DEPTH   = 128;

    localparam int FB_SIZE = DISPLAY_COLUMNS * DISPLAY_PAGES;
    localparam int FB_AW   = $clog2(FB_SIZE);
    localparam int PAT_AW  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int PG_W    = (DISPLAY_PAGES > 1) ? $clog2(DISPLAY_PAGES) : 1;
    localparam int COLI_W  = $clog2(DISPLAY_COLUMNS);
    localparam int RGT_W   = $clog2(DISPLAY_COLUMNS + 1);
    localparam int LEN_W   = 8;
    localparam int PROD_W  = 16;
    localparam int SETUP_W = 10;

    // commands
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_DRAW = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // blend modes
    localparam logic [1:0] BLEND_SET = 2'd0;
    localparam logic [1:0] BLEND_OR  = 2'd1;
    localparam logic [1:0] BLEND_AND = 2'd2;
    localparam logic [1:0] BLEND_XOR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_AREA_LEFT   = 2'd0;
    localparam logic [1:0] REG_AREA_TOP    = 2'd1;
    localparam logic [1:0] REG_AREA_RIGHT  = 2'd2;
    localparam logic [1:0] REG_AREA_BOTTOM = 2'd3;

    typedef struct packed {
        logic       invert;
        logic [1:0] mode;
    } t_blend_ctl;

endpackage

`default_nettype wire

@@ rtl/cbb_blend_unit.sv @@
// ----------------------------------------------------------------------------
// cbb_blend_unit
// raster op unit: optional complement of the pattern byte, then set/or/and/xor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbb_blend_unit
    import cbb_pkg::*;
(
    input  wire logic [7:0] i_old,
    input  wire logic [7:0] i_pat,
    input  wire t_blend_ctl i_ctl,
    output logic      [7:0] o_new
);

    logic [7:0] pix;

    always_comb begin
        pix = i_ctl.invert ? ~i_pat : i_pat;
        case (i_ctl.mode)
            BLEND_SET: o_new = pix;
            BLEND_OR:  o_new = i_old | pix;
            BLEND_AND: o_new = i_old & pix;
            BLEND_XOR: o_new = i_old ^ pix;
            default:   o_new = pix;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/column_bitmap_blitter.sv @@
// ----------------------------------------------------------------------------
// column_bitmap_blitter
// repeated-pattern blitter for a page-organized monochrome frame buffer
// ----------------------------------------------------------------------------
// After reset the block sweeps the 1024-byte frame buffer to zero, one byte a
// cycle, and accepts its first word only once the sweep is done
// (configuration writes are taken during the sweep). One word is handled at a
// time. A load passes through S_DONE, a read through S_RDWAIT and S_DONE, and
// a draw through S_SETUP, S_CLIP, S_DRAW and S_DONE (a clipped or empty draw
// skips S_DRAW). The draw rate is one column per cycle, set by the
// frame buffer's one read and one write port running a two-stage
// read-modify-write pipeline through the blend unit. A finished result
// waits in the output register while the next word is accepted.
`timescale 1ns / 1ps
`default_nettype none

module column_bitmap_blitter
    import cbb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    // input words
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_command,
    input  wire logic [6:0] i_pattern_index,
    input  wire logic [7:0] i_pattern_byte,
    input  wire logic [7:0] i_x,
    input  wire logic [7:0] i_y,
    input  wire logic [7:0] i_length,
    input  wire logic [7:0] i_repeats,
    input  wire logic       i_reverse,
    input  wire logic       i_invert,
    input  wire logic [1:0] i_blend_mode,
    input  wire logic [9:0] i_read_address,
    // results
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic      [7:0] o_drawn_count,
    output logic      [7:0] o_read_data
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_CLIP   = 3'd3;
    localparam logic [2:0] S_DRAW   = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // memories
    logic [7:0] m_fb  [FB_SIZE];
    logic [7:0] m_pat [PATTERN_DEPTH];

    // control state
    logic [2:0]       r_state, n_state;
    logic [FB_AW-1:0] r_clr_addr, n_clr_addr;
    logic             r_out_valid, n_out_valid;
    logic             r_wb_vld, n_wb_vld;
    logic [6:0]       r_area_left;
    logic [2:0]       r_area_top;
    logic [7:0]       r_area_right;
    logic [3:0]       r_area_bottom;

    // payload state
    logic [7:0]        r_x, n_x;
    logic [7:0]        r_y, n_y;
    logic [7:0]        r_len, n_len;
    logic [7:0]        r_rep, n_rep;
    logic              r_rev, n_rev;
    t_blend_ctl        r_ctl, n_ctl;
    logic              r_start_ok, n_start_ok;
    logic [RGT_W-1:0]  r_avail, n_avail;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [PG_W-1:0]   r_row, n_row;
    logic [COLI_W-1:0] r_col, n_col;
    logic [LEN_W-1:0]  r_lenc, n_lenc;
    logic [PAT_AW-1:0] r_p, n_p;
    logic [RGT_W-1:0]  r_remain, n_remain;
    logic [RGT_W-1:0]  r_count, n_count;
    logic [FB_AW-1:0]  r_wb_addr, n_wb_addr;
    logic              r_rd_oob, n_rd_oob;
    logic [7:0]        r_res_count, n_res_count;
    logic [7:0]        r_res_data, n_res_data;
    logic [7:0]        r_drawn, n_drawn;
    logic [7:0]        r_rdata, n_rdata;
    logic [7:0]        r_fb_q;
    logic [7:0]        r_pat_q;

    // memory ports
    logic             fb_we;
    logic [FB_AW-1:0] fb_wa;
    logic [7:0]       fb_wd;
    logic [FB_AW-1:0] fb_ra;
    logic             pat_we;
    logic [7:0]       blend_q;

    // setup arithmetic
    logic [SETUP_W-1:0] s_ax, s_ay, s_right, s_bottom;
    logic [LEN_W-1:0]   s_lenc;
    logic [RGT_W-1:0]   c_count;
    logic [FB_AW-1:0]   draw_addr;
    logic               in_acc;

    assign in_acc    = i_in_valid && o_in_ready;
    assign draw_addr = FB_AW'(r_row) * FB_AW'(DISPLAY_COLUMNS) + FB_AW'(r_col);

    cbb_blend_unit u_blend (
        .i_old (r_fb_q),
        .i_pat (r_pat_q),
        .i_ctl (r_ctl),
        .o_new (blend_q)
    );

    always_comb begin
        s_ax     = SETUP_W'(r_area_left) + SETUP_W'(r_x);
        s_ay     = SETUP_W'(r_area_top) + SETUP_W'(r_y);
        s_right  = (SETUP_W'(r_area_right) < SETUP_W'(DISPLAY_COLUMNS)) ?
                   SETUP_W'(r_area_right) : SETUP_W'(DISPLAY_COLUMNS);
        s_bottom = (SETUP_W'(r_area_bottom) < SETUP_W'(DISPLAY_PAGES)) ?
                   SETUP_W'(r_area_bottom) : SETUP_W'(DISPLAY_PAGES);
        s_lenc   = (SETUP_W'(r_len) > SETUP_W'(PATTERN_DEPTH)) ?
                   LEN_W'(PATTERN_DEPTH) : r_len;
        c_count  = (r_prod < PROD_W'(r_avail)) ? RGT_W'(r_prod) : r_avail;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        n_wb_vld    = 1'b0;
        n_x         = r_x;
        n_y         = r_y;
        n_len       = r_len;
        n_rep       = r_rep;
        n_rev       = r_rev;
        n_ctl       = r_ctl;
        n_start_ok  = r_start_ok;
        n_avail     = r_avail;
        n_prod      = r_prod;
        n_row       = r_row;
        n_col       = r_col;
        n_lenc      = r_lenc;
        n_p         = r_p;
        n_remain    = r_remain;
        n_count     = r_count;
        n_wb_addr   = r_wb_addr;
        n_rd_oob    = r_rd_oob;
        n_res_count = r_res_count;
        n_res_data  = r_res_data;
        n_drawn     = r_drawn;
        n_rdata     = r_rdata;
        fb_ra       = draw_addr;
        pat_we      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == FB_AW'(FB_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                fb_ra = FB_AW'(i_read_address);
                if (in_acc) begin
                    n_x         = i_x;
                    n_y         = i_y;
                    n_len       = i_length;
                    n_rep       = i_repeats;
                    n_rev       = i_reverse;
                    n_ctl       = '{invert: i_invert, mode: i_blend_mode};
                    n_rd_oob    = ({1'b0, i_read_address} >= 11'(FB_SIZE));
                    n_res_count = 8'd0;
                    n_res_data  = 8'd0;
                    case (i_command)
                        CMD_LOAD: begin
                            pat_we  = (8'(i_pattern_index) < 8'(PATTERN_DEPTH));
                            n_state = S_DONE;
                        end
                        CMD_DRAW: n_state = S_SETUP;
                        CMD_READ: n_state = S_RDWAIT;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SETUP: begin
                n_start_ok = (s_ax < s_right) && (s_ay < s_bottom);
                n_avail    = RGT_W'(s_right - s_ax);
                n_row      = PG_W'(s_ay);
                n_col      = COLI_W'(s_ax);
                n_lenc     = s_lenc;
                n_prod     = PROD_W'(s_lenc) * PROD_W'(r_rep);
                n_state    = S_CLIP;
            end
            S_CLIP: begin
                if (!r_start_ok || c_count == '0) begin
                    n_res_count = 8'd0;
                    n_state     = S_DONE;
                end else begin
                    n_remain = c_count;
                    n_count  = c_count;
                    n_p      = r_rev ? PAT_AW'(r_lenc - 1'b1) : '0;
                    n_state  = S_DRAW;
                end
            end
            S_DRAW: begin
                // issue the read of the next column while the previous one is written
                if (r_remain != '0) begin
                    n_wb_vld  = 1'b1;
                    n_wb_addr = draw_addr;
                    n_remain  = r_remain - 1'b1;
                    n_col     = r_col + 1'b1;
                    if (r_rev) begin
                        n_p = (r_p == '0) ? PAT_AW'(r_lenc - 1'b1) : r_p - 1'b1;
                    end else begin
                        n_p = ((LEN_W'(r_p) + 1'b1) >= r_lenc) ? '0 : r_p + 1'b1;
                    end
                end else if (!r_wb_vld) begin
                    n_res_count = 8'(r_count);
                    n_state     = S_DONE;
                end
            end
            S_RDWAIT: begin
                n_res_data = r_rd_oob ? 8'd0 : r_fb_q;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_drawn     = r_res_count;
                    n_rdata     = r_res_data;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // frame buffer write port: clearing sweep or draw write-back
    always_comb begin
        if (r_state == S_CLEAR) begin
            fb_we = 1'b1;
            fb_wa = r_clr_addr;
            fb_wd = 8'd0;
        end else begin
            fb_we = r_wb_vld;
            fb_wa = r_wb_addr;
            fb_wd = blend_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            m_fb[fb_wa] <= fb_wd;
        end
        r_fb_q <= m_fb[fb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            m_pat[PAT_AW'(i_pattern_index)] <= i_pattern_byte;
        end
        r_pat_q <= m_pat[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
            r_wb_vld      <= 1'b0;
            r_area_left   <= 7'd0;
            r_area_top    <= 3'd0;
            r_area_right  <= 8'd128;
            r_area_bottom <= 4'd8;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_wb_vld    <= n_wb_vld;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_AREA_LEFT:   r_area_left   <= i_cfg_data[6:0];
                    REG_AREA_TOP:    r_area_top    <= i_cfg_data[2:0];
                    REG_AREA_RIGHT:  r_area_right  <= i_cfg_data;
                    REG_AREA_BOTTOM: r_area_bottom <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_y         <= n_y;
        r_len       <= n_len;
        r_rep       <= n_rep;
        r_rev       <= n_rev;
        r_ctl       <= n_ctl;
        r_start_ok  <= n_start_ok;
        r_avail     <= n_avail;
        r_prod      <= n_prod;
        r_row       <= n_row;
        r_col       <= n_col;
        r_lenc      <= n_lenc;
        r_p         <= n_p;
        r_remain    <= n_remain;
        r_count     <= n_count;
        r_wb_addr   <= n_wb_addr;
        r_rd_oob    <= n_rd_oob;
        r_res_count <= n_res_count;
        r_res_data  <= n_res_data;
        r_drawn     <= n_drawn;
        r_rdata     <= n_rdata;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_drawn_count = r_drawn;
    assign o_read_data   = r_rdata;

endmodule

`default_nettype wire

@@ rtl/cbb_checker.sv @@
// ----------------------------------------------------------------------------
// cbb_checker
// port-level assertions for the column bitmap blitter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "column_bitmap_blitter_macros.svh"

module cbb_checker
    import cbb_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_drawn_count,
    input wire logic [7:0] o_read_data
);

    logic [15:0] out_word;

    assign out_word = {o_drawn_count, o_read_data};

    // a stalled result holds
    `CBB_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(out_word))

    // one word in flight: ready drops right after an accept
    `CBB_ASSERT_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // a result carries a draw count or read data, never both
    `CBB_ASSERT_IMP(a_one_field, o_out_valid, o_drawn_count == 8'd0 || o_read_data == 8'd0)

    // a draw never covers more than one display row
    `CBB_ASSERT_IMP(a_count_bound, o_out_valid, 9'(o_drawn_count) <= 9'(DISPLAY_COLUMNS))

endmodule

bind column_bitmap_blitter cbb_checker u_cbb_checker (.*);

`default_nettype wire
